// ----- hdl/dvsd_pkg.sv -----
// Package for the delta-coded varint score decoder.
// Holds the transfer structs, phase and result codes and the varint constants.
// No dependencies.
package dvsd_pkg;

	localparam logic [7:0] GROUP_MASK = 8'h7F;
	localparam logic [7:0] MORE_BIT   = 8'h80;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_DELTA = 3'd2,
		PH_SCORE = 3'd3,
		PH_ERROR = 3'd4
	} phase_t;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_flag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] offset_value;
		logic [31:0] score_bits;
		logic [31:0] entry_index;
		logic [31:0] array_count;
		logic        last_flag;
	} out_item_t;

endpackage

// ----- hdl/delta_varint_score_decoder.sv -----
// Top level of the delta-coded varint score decoder: input register, result register.
// Instantiates dvsd_core; depends on dvsd_pkg.
//
//   channel | signals                      | payload
//   in      | in_valid, in_ready           | in_data  (dvsd_pkg::in_item_t)
//   out     | out_valid, out_ready         | out_data (dvsd_pkg::out_item_t)
//   cfg     | cfg_valid, cfg_ready         | cfg_data (type code, 8 bits)
//
// One byte per cycle while no result is held; the result register loads when its byte is decoded.
// The decode step between the input and result registers sets the rate.
// Reset clears the phase, counters and both valid flags; type code resets to 0.
// A held result stalls decoding; the input register still takes one byte meanwhile.
// cfg_ready is always high.
module delta_varint_score_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dvsd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dvsd_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	logic               valid_s1;
	dvsd_pkg::in_item_t item_s1;
	logic               out_valid_q;
	dvsd_pkg::out_item_t out_q;
	logic [7:0]         type_code_q;

	logic               out_free;
	logic               take;
	logic               emit;
	dvsd_pkg::out_item_t result;

	assign out_free  = !out_valid_q || out_ready;
	assign take      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_code_q <= '0;
		end else if (cfg_valid) begin
			type_code_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	dvsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.item      (item_s1),
		.type_code (type_code_q),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.result_kind == dvsd_pkg::KIND_ENTRY
			|| out_q.result_kind == dvsd_pkg::KIND_EMPTY
			|| out_q.result_kind == dvsd_pkg::KIND_ERROR)
		else $error("reserved result kind");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == dvsd_pkg::KIND_ERROR
		|-> out_q.last_flag && out_q.offset_value == 64'd0 && out_q.array_count == 32'd0)
		else $error("error result fields wrong");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == dvsd_pkg::KIND_ENTRY
		|-> out_q.entry_index < out_q.array_count)
		else $error("entry index beyond count");

	a_last_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == dvsd_pkg::KIND_ENTRY && out_q.last_flag
		|-> out_q.entry_index + 32'd1 == out_q.array_count)
		else $error("last flag on wrong entry");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held result");
`endif

endmodule

// ----- hdl/dvsd_core.sv -----
// Decode state machine: phase, varint accumulator, offset, counters, score assembly.
// Consumes one registered byte per step and flags a result when one is due.
// Depends on dvsd_pkg.
module dvsd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  dvsd_pkg::in_item_t item,
	input  logic [7:0]        type_code,
	output logic              emit,
	output dvsd_pkg::out_item_t result
);

	dvsd_pkg::phase_t phase_q, phase_n;
	logic [63:0] acc_q, acc_n;
	logic [63:0] offset_q, offset_n;
	logic [31:0] total_q, total_n;
	logic [31:0] done_q, done_n;
	logic [23:0] sa_q, sa_n;
	logic [1:0]  cnt_q, cnt_n;

	logic [63:0] acc_shift;
	logic        more;
	logic [31:0] done_inc;
	logic        last;

	assign acc_shift = {acc_q[56:0], item.data_byte[6:0] & dvsd_pkg::GROUP_MASK[6:0]};
	assign more      = (item.data_byte & dvsd_pkg::MORE_BIT) != 8'd0;
	assign done_inc  = done_q + 32'd1;
	assign last      = done_inc == total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dvsd_pkg::PH_IDLE;
			acc_q    <= '0;
			offset_q <= '0;
			total_q  <= '0;
			done_q   <= '0;
			sa_q     <= '0;
			cnt_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			offset_q <= offset_n;
			total_q  <= total_n;
			done_q   <= done_n;
			sa_q     <= sa_n;
			cnt_q    <= cnt_n;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		offset_n = offset_q;
		total_n  = total_q;
		done_n   = done_q;
		sa_n     = sa_q;
		cnt_n    = cnt_q;
		emit     = 1'b0;
		result   = '0;
		if (item.start_flag) begin
			acc_n    = '0;
			offset_n = '0;
			total_n  = '0;
			done_n   = '0;
			sa_n     = '0;
			cnt_n    = '0;
			if (item.data_byte == type_code) begin
				phase_n = dvsd_pkg::PH_COUNT;
			end else begin
				phase_n            = dvsd_pkg::PH_ERROR;
				emit               = 1'b1;
				result.result_kind = dvsd_pkg::KIND_ERROR;
				result.last_flag   = 1'b1;
			end
		end else begin
			unique case (phase_q)
				dvsd_pkg::PH_COUNT: begin
					acc_n = acc_shift;
					if (!more) begin
						total_n = acc_shift[31:0];
						acc_n   = '0;
						if (acc_shift[31:0] == 32'd0) begin
							phase_n            = dvsd_pkg::PH_IDLE;
							emit               = 1'b1;
							result.result_kind = dvsd_pkg::KIND_EMPTY;
							result.last_flag   = 1'b1;
						end else begin
							phase_n = dvsd_pkg::PH_DELTA;
						end
					end
				end
				dvsd_pkg::PH_DELTA: begin
					acc_n = acc_shift;
					if (!more) begin
						offset_n = offset_q + acc_shift;
						acc_n    = '0;
						sa_n     = '0;
						cnt_n    = '0;
						phase_n  = dvsd_pkg::PH_SCORE;
					end
				end
				dvsd_pkg::PH_SCORE: begin
					unique case (cnt_q)
						2'd0: begin
							sa_n[7:0] = item.data_byte;
							cnt_n     = 2'd1;
						end
						2'd1: begin
							sa_n[15:8] = item.data_byte;
							cnt_n      = 2'd2;
						end
						2'd2: begin
							sa_n[23:16] = item.data_byte;
							cnt_n       = 2'd3;
						end
						default: begin
							emit                = 1'b1;
							result.result_kind  = dvsd_pkg::KIND_ENTRY;
							result.offset_value = offset_q;
							result.score_bits   = {item.data_byte, sa_q};
							result.entry_index  = done_q;
							result.array_count  = total_q;
							result.last_flag    = last;
							done_n              = done_inc;
							sa_n                = '0;
							cnt_n               = '0;
							acc_n               = '0;
							phase_n             = last ? dvsd_pkg::PH_IDLE : dvsd_pkg::PH_DELTA;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sim/delta_varint_score_decoder_tb.sv -----
// Testbench for delta_varint_score_decoder: drives encoded byte streams and
// checks every result field against an in-bench decoder of the same format.
// Depends on dvsd_pkg and the RTL of the block; stands alone otherwise.
module delta_varint_score_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	dvsd_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	dvsd_pkg::out_item_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data = 8'h00;

	// decoder state mirrored in the bench
	logic [7:0]        type_code = 8'h00;
	dvsd_pkg::phase_t  cur_phase = dvsd_pkg::PH_IDLE;
	logic [63:0]       acc = '0;
	logic [63:0]       run_offset = '0;
	logic [31:0]       total_entries = '0;
	logic [31:0]       done_entries = '0;
	logic [23:0]       score_low = '0;
	logic [1:0]        score_count = '0;

	dvsd_pkg::out_item_t decoded_queue[$];
	dvsd_pkg::out_item_t head;
	int        mismatches = 0;
	int        byte_count = 0;
	int        hold_count = 0;
	bit        quiet = 1'b0;

	delta_varint_score_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void decode_byte(input logic [7:0] b, input logic s);
		dvsd_pkg::out_item_t r;
		bit        last;
		r = '0;
		if (s) begin
			acc = '0;
			run_offset = '0;
			total_entries = '0;
			done_entries = '0;
			score_low = '0;
			score_count = '0;
			if (b == type_code) begin
				cur_phase = dvsd_pkg::PH_COUNT;
				return;
			end
			cur_phase = dvsd_pkg::PH_ERROR;
			r.result_kind = dvsd_pkg::KIND_ERROR;
			r.last_flag = 1'b1;
			decoded_queue.push_back(r);
			return;
		end
		case (cur_phase)
			dvsd_pkg::PH_COUNT: begin
				acc = (acc << 7) | 64'(b & dvsd_pkg::GROUP_MASK);
				if ((b & dvsd_pkg::MORE_BIT) == 8'h00) begin
					total_entries = acc[31:0];
					acc = '0;
					if (total_entries == 32'd0) begin
						cur_phase = dvsd_pkg::PH_IDLE;
						r.result_kind = dvsd_pkg::KIND_EMPTY;
						r.last_flag = 1'b1;
						decoded_queue.push_back(r);
					end else begin
						cur_phase = dvsd_pkg::PH_DELTA;
					end
				end
			end
			dvsd_pkg::PH_DELTA: begin
				acc = (acc << 7) | 64'(b & dvsd_pkg::GROUP_MASK);
				if ((b & dvsd_pkg::MORE_BIT) == 8'h00) begin
					run_offset = run_offset + acc;
					acc = '0;
					score_low = '0;
					score_count = '0;
					cur_phase = dvsd_pkg::PH_SCORE;
				end
			end
			dvsd_pkg::PH_SCORE: begin
				if (score_count < 2'd3) begin
					score_low[8 * score_count +: 8] = b;
					score_count = score_count + 2'd1;
				end else begin
					last = (32'(done_entries + 32'd1) == total_entries);
					r.result_kind = dvsd_pkg::KIND_ENTRY;
					r.offset_value = run_offset;
					r.score_bits = {b, score_low};
					r.entry_index = done_entries;
					r.array_count = total_entries;
					r.last_flag = last;
					decoded_queue.push_back(r);
					done_entries = done_entries + 32'd1;
					score_low = '0;
					score_count = '0;
					acc = '0;
					cur_phase = last ? dvsd_pkg::PH_IDLE : dvsd_pkg::PH_DELTA;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 64'($urandom_range(0, 127));
			4, 5:       return 64'($urandom_range(0, 16383));
			6:          return {32'h0, 32'($urandom)};
			7:          return {32'($urandom), 32'($urandom)};
			8:          return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
			default:    return 64'h0;
		endcase
	endfunction

	function automatic logic [63:0] pick_count();
		int r;
		r = $urandom_range(0, 11);
		if (r < 8)
			return 64'($urandom_range(1, 6));
		if (r == 8)
			return 64'h0;
		if (r == 9)
			return 64'($urandom_range(10, 16));
		if (r == 10)
			return {24'h0, 8'($urandom_range(1, 255)), 32'h0};
		return {24'h0, 8'($urandom), 32'($urandom_range(1, 3))};
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = {b, s};
		do @(posedge clk); while (!in_ready);
		decode_byte(b, s);
		byte_count++;
	endtask

	task automatic send_varint(input logic [63:0] v, input int pad);
		int          n;
		logic [63:0] t;
		n = 1;
		t = v >> 7;
		while (t != 0) begin
			n++;
			t = t >> 7;
		end
		repeat (pad) send_byte(dvsd_pkg::MORE_BIT, 1'b0);
		for (int i = n - 1; i >= 0; i--)
			send_byte(8'((v >> (7 * i)) & 64'(dvsd_pkg::GROUP_MASK))
				| (i > 0 ? dvsd_pkg::MORE_BIT : 8'h00), 1'b0);
	endtask

	// more groups than fit in 64 bits
	task automatic send_overlong();
		int n;
		n = $urandom_range(11, 14);
		repeat (n - 1) send_byte(8'($urandom_range(0, 127)) | dvsd_pkg::MORE_BIT, 1'b0);
		send_byte(8'($urandom_range(0, 127)), 1'b0);
	endtask

	task automatic send_entry();
		if ($urandom_range(0, 11) == 0)
			send_overlong();
		else
			send_varint(pick_value(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
		repeat (4) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_array(input logic [63:0] count, input int entries, input bit cut);
		send_byte(type_code, 1'b1);
		send_varint(count, ($urandom_range(0, 7) == 0) ? 1 : 0);
		for (int e = 0; e < entries; e++)
			send_entry();
		if (cut) begin
			if ($urandom_range(0, 1) == 0) begin
				send_byte(8'($urandom) | dvsd_pkg::MORE_BIT, 1'b0);
			end else begin
				send_varint(pick_value(), 0);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	task automatic write_type_code(input logic [7:0] code);
		@(negedge clk);
		in_valid = 1'b0;
		while (decoded_queue.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = code;
		do @(posedge clk); while (!cfg_ready);
		type_code = code;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_error_and_ignore();
		send_byte(~type_code, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_empty_and_restart();
		send_byte(type_code, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(type_code, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(type_code, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_two_entries();
		send_byte(type_code, 1'b1);
		send_byte(8'h02, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		repeat (4) send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		repeat (4) send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_backpressure();
		hold_count = 200;
		quiet = 1'b1;
		repeat (3) send_array(64'd8, 8, 1'b0);
		quiet = 1'b0;
	endtask

	task automatic test_random_arrays(input int budget);
		int          stop_at;
		int          r;
		int          n;
		logic [63:0] c;
		stop_at = byte_count + budget;
		while (byte_count < stop_at) begin
			quiet = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 19);
			if (r < 13) begin
				c = pick_count();
				send_array(c, int'(c[31:0]), 1'b0);
			end else if (r < 15) begin
				n = $urandom_range(2, 6);
				send_array(64'(n), $urandom_range(0, n - 1), 1'b1);
			end else if (r < 17) begin
				send_byte(type_code ^ 8'($urandom_range(1, 255)), 1'b1);
				repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
			end else if (r < 18) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
			end else begin
				send_byte(type_code, 1'b1);
				send_overlong();
				send_entry();
			end
		end
		quiet = 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (decoded_queue.size() == 0) begin
				$display("%0t: result expected none actual %p", $time, out_data);
				mismatches++;
			end else begin
				head = decoded_queue.pop_front();
				check_field("result_kind", 64'(head.result_kind), 64'(out_data.result_kind));
				check_field("offset_value", head.offset_value, out_data.offset_value);
				check_field("score_bits", 64'(head.score_bits), 64'(out_data.score_bits));
				check_field("entry_index", 64'(head.entry_index), 64'(out_data.entry_index));
				check_field("array_count", 64'(head.array_count), 64'(out_data.array_count));
				check_field("last_flag", 64'(head.last_flag), 64'(out_data.last_flag));
			end
		end
	end

	initial begin : receiver
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_count > 0) begin
				out_ready = 1'b0;
				hold_count--;
			end else if (quiet) begin
				out_ready = 1'b1;
				stall = 0;
			end else if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_type_code(8'h00);
		test_error_and_ignore();
		test_empty_and_restart();
		test_two_entries();
		write_type_code(8'hFF);
		test_random_arrays(100);
		test_backpressure();
		write_type_code(8'h80);
		test_random_arrays(100);
		write_type_code(8'($urandom));
		test_random_arrays(100);
		write_type_code(8'h7F);
		test_random_arrays(100);
		write_type_code(8'h00);
		test_random_arrays(100);

		@(negedge clk);
		in_valid = 1'b0;
		while (decoded_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
